/* hw/rtl/hamming_sec_check_store_macros.svh */
// assertion macros for the hamming check store
// used by the top level, relies on i_clk and i_rst_n being in scope
`ifndef HAMMING_SEC_CHECK_STORE_MACROS_SVH
`define HAMMING_SEC_CHECK_STORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define HSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define HSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hsc_pkg.sv */
// shared types, constants and code-position table for the hamming check store
// no dependencies
package hsc_pkg;

    localparam int SLOT_W          = 10;
    localparam int BC_W            = 4;
    localparam int DATA_W          = 64;
    localparam int SYN_W           = 7;
    localparam int MAX_BYTES       = 8;
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [BC_W-1:0]   size;
        logic [SYN_W-1:0]  check;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [SYN_W-1:0]  syndrome;
        logic              checked;
        logic              corrected;
        logic              uncorrectable;
    } t_flags;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_init_state;

    typedef logic [SYN_W-1:0] t_pos_tbl [DATA_W];

    // code position of each data bit: the non-power-of-two positions in order
    function automatic t_pos_tbl build_pos_tbl();
        t_pos_tbl tbl;
        int       p;
        p = 1;
        for (int k = 0; k < DATA_W; k++) begin
            while ((p & (p - 1)) == 0) begin
                p++;
            end
            tbl[k] = SYN_W'(p);
            p++;
        end
        return tbl;
    endfunction

    localparam t_pos_tbl DATA_POS = build_pos_tbl();

    // data bit k sits in byte k/8, msb first
    function automatic logic [5:0] data_bit_at(input int k);
        int b;
        b = ((k >> 3) << 3) + 7 - (k & 7);
        return b[5:0];
    endfunction

endpackage

/* hw/rtl/hsc_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module hsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/hsc_slot_map.sv */
// folds the 10-bit slot onto the table depth
// depends on hsc_pkg
module hsc_slot_map
    import hsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic [SLOT_W-1:0] i_slot,
    output logic [AW-1:0]     o_idx
);

    generate
        if (TABLE_DEPTH == 1) begin : g_one
            assign o_idx = '0;
        end else if (TABLE_DEPTH >= (1 << SLOT_W)) begin : g_wide
            assign o_idx = AW'(i_slot);
        end else if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_pow2
            assign o_idx = i_slot[AW-1:0];
        end else begin : g_rem
            logic [SLOT_W-1:0] rem;
            // restoring remainder against shifted copies of the depth
            always_comb begin
                rem = i_slot;
                for (int j = SLOT_W - 1; j >= 0; j--) begin
                    if ((TABLE_DEPTH << j) < (1 << SLOT_W)) begin
                        if (int'(rem) >= (TABLE_DEPTH << j)) begin
                            rem = rem - SLOT_W'(TABLE_DEPTH << j);
                        end
                    end
                end
            end
            assign o_idx = rem[AW-1:0];
        end
    endgenerate

endmodule

/* hw/rtl/hsc_codec.sv */
// check word generation, syndrome and single-bit correction for one item
// depends on hsc_pkg
module hsc_codec
    import hsc_pkg::*;
(
    input  logic              i_action,
    input  logic [BC_W-1:0]   i_byte_count,
    input  logic [DATA_W-1:0] i_data,
    input  t_entry            i_entry,
    output logic [SYN_W-1:0]  o_check,
    output logic [DATA_W-1:0] o_data,
    output t_flags            o_flags
);

    logic [BC_W-1:0]   eff;
    logic [DATA_W-1:0] covered;
    logic [SYN_W-1:0]  check;
    logic [SYN_W-1:0]  syn;
    logic              chk;
    logic [DATA_W-1:0] flip;

    always_comb begin
        priority if (i_byte_count == '0) begin
            eff = BC_W'(1);
        end else if (i_byte_count > BC_W'(MAX_BYTES)) begin
            eff = BC_W'(MAX_BYTES);
        end else begin
            eff = i_byte_count;
        end
    end

    always_comb begin
        covered = '0;
        check   = '0;
        for (int k = 0; k < DATA_W; k++) begin
            covered[k] = (BC_W'(k >> 3) < eff);
            if (covered[k] && i_data[data_bit_at(k)]) begin
                check = check ^ DATA_POS[k];
            end
        end
    end

    assign chk = (i_action == ACT_READ) && i_entry.valid && (i_entry.size == i_byte_count);
    assign syn = chk ? (check ^ i_entry.check) : '0;

    // positions are distinct and nonzero, so at most one bit matches
    always_comb begin
        flip = '0;
        for (int k = 0; k < DATA_W; k++) begin
            if (covered[k] && (syn == DATA_POS[k])) begin
                flip[data_bit_at(k)] = 1'b1;
            end
        end
    end

    assign o_check               = check;
    assign o_data                = i_data ^ flip;
    assign o_flags.syndrome      = syn;
    assign o_flags.checked       = chk;
    assign o_flags.corrected     = |flip;
    assign o_flags.uncorrectable = (syn != '0) && !(|flip);

endmodule

/* hw/rtl/hamming_sec_check_store.sv */
// top level of the hamming check store: slot table, codec and output register
// depends on hsc_pkg, hsc_ram, hsc_slot_map, hsc_codec and the macro header
//
//  channel   handshake            payload
//  input     i_valid / o_ready    i_action, i_slot, i_byte_count, i_data_in
//  output    o_valid / i_ready    o_data_out, o_syndrome, o_checked,
//                                 o_corrected, o_uncorrectable
//
// one item per cycle sustained while i_ready stays high; the table ram read is
// registered into stage one, then the codec runs in a single pass into the
// output register, which drives o_valid. a write followed at once by a read of
// the same slot is forwarded. after reset the table is swept clear, one entry a
// cycle, with o_ready low throughout the sweep. a stalled output holds the
// result and one more item in the stage behind it; outside the sweep o_ready
// falls only when both are full and i_ready is low.
`include "hamming_sec_check_store_macros.svh"

module hamming_sec_check_store
    import hsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [BC_W-1:0]   i_byte_count,
    input  logic [DATA_W-1:0] i_data_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data_out,
    output logic [SYN_W-1:0]  o_syndrome,
    output logic              o_checked,
    output logic              o_corrected,
    output logic              o_uncorrectable
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_init_state r_state, n_state;
    logic [AW-1:0] r_clr_idx, n_clr_idx;
    logic          clearing;

    logic              r_s1_valid;
    logic              r_s1_action;
    logic [BC_W-1:0]   r_s1_bc;
    logic [DATA_W-1:0] r_s1_data;
    logic [AW-1:0]     r_s1_idx;
    logic              r_fwd_hit;
    t_entry            r_fwd_entry;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    t_flags            r_out_flags;

    logic [AW-1:0]      in_idx;
    logic               accept;
    logic               s1_adv;
    logic               s1_write;
    logic               fwd_now;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    t_entry             rd_entry;
    t_entry             wr_entry;
    logic [SYN_W-1:0]   cw_check;
    logic [DATA_W-1:0]  cw_data;
    t_flags             cw_flags;

    // clearing sweep after reset
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    hsc_slot_map #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot_map (
        .i_slot (i_slot),
        .o_idx  (in_idx)
    );

    assign s1_adv   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready  = !clearing && (!r_s1_valid || s1_adv);
    assign accept   = i_valid && o_ready;
    assign s1_write = s1_adv && (r_s1_action == ACT_WRITE);
    // the ram reads the old entry while stage one writes the same slot
    assign fwd_now  = s1_write && (r_s1_idx == in_idx);

    assign wr_entry.valid = 1'b1;
    assign wr_entry.size  = r_s1_bc;
    assign wr_entry.check = cw_check;

    assign ram_we    = clearing || s1_write;
    assign ram_waddr = clearing ? r_clr_idx : r_s1_idx;
    assign ram_wdata = clearing ? '0 : wr_entry;

    hsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = r_fwd_hit ? r_fwd_entry : t_entry'(ram_rdata);

    hsc_codec u_codec (
        .i_action     (r_s1_action),
        .i_byte_count (r_s1_bc),
        .i_data       (r_s1_data),
        .i_entry      (rd_entry),
        .o_check      (cw_check),
        .o_data       (cw_data),
        .o_flags      (cw_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= fwd_now;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_action;
            r_s1_bc     <= i_byte_count;
            r_s1_data   <= i_data_in;
            r_s1_idx    <= in_idx;
            r_fwd_entry <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data  <= cw_data;
            r_out_flags <= cw_flags;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_data_out      = r_out_data;
    assign o_syndrome      = r_out_flags.syndrome;
    assign o_checked       = r_out_flags.checked;
    assign o_corrected     = r_out_flags.corrected;
    assign o_uncorrectable = r_out_flags.uncorrectable;

    `HSC_ASSERT_IMP(a_no_accept_in_clear, r_state == ST_CLEAR, !o_ready, "item taken in clear")
    `HSC_ASSERT_IMP(a_flags_exclusive, o_valid, !(o_corrected && o_uncorrectable), "flag clash")
    `HSC_ASSERT_IMP(a_unchk_quiet, o_valid && !o_checked, r_out_flags == '0, "stray flags")
    `HSC_ASSERT_NXT(a_s1_to_out, s1_adv, o_valid, "stage one advance lost")

endmodule

/* tb/sv/tb_top.sv */
// testbench for hamming_sec_check_store: directed and random accesses with a local
// predictor of the check-word store; depends on hsc_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_top;
    import hsc_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [SYN_W-1:0]  syndrome;
        logic              checked;
        logic              corrected;
        logic              uncorrectable;
    } t_access_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_action     = ACT_WRITE;
    logic [SLOT_W-1:0] i_slot       = '0;
    logic [BC_W-1:0]   i_byte_count = '0;
    logic [DATA_W-1:0] i_data_in    = '0;
    logic              i_ready      = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [DATA_W-1:0] o_data_out;
    logic [SYN_W-1:0]  o_syndrome;
    logic              o_checked;
    logic              o_corrected;
    logic              o_uncorrectable;

    hamming_sec_check_store #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_action(i_action),
        .i_slot(i_slot),
        .i_byte_count(i_byte_count),
        .i_data_in(i_data_in),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data_out(o_data_out),
        .o_syndrome(o_syndrome),
        .o_checked(o_checked),
        .o_corrected(o_corrected),
        .o_uncorrectable(o_uncorrectable)
    );

    // predictor copy of the slot table
    logic [SYN_W-1:0] chk_mem   [DEPTH];
    logic [BC_W-1:0]  size_mem  [DEPTH];
    bit               valid_mem [DEPTH];
    int               code_pos  [DATA_W];

    // what was last written per slot, used only to build reads
    logic [DATA_W-1:0] wr_data  [DEPTH];
    logic [BC_W-1:0]   wr_count [DEPTH];
    bit                wr_seen  [DEPTH];
    int                written_slots [$];
    int                last_written;

    t_access_result expected_results [$];

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          errors    = 0;
    int unsigned cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int lane_bit(int k);
        return 8 * (k / 8) + 7 - (k % 8);
    endfunction

    // coverage uses the count clamped into 1..MAX_BYTES
    function automatic int covered_bits(logic [BC_W-1:0] bc);
        int n;
        n = bc;
        if (n < 1) n = 1;
        if (n > MAX_BYTES) n = MAX_BYTES;
        return 8 * n;
    endfunction

    function automatic logic [SYN_W-1:0] calc_check_word(logic [DATA_W-1:0] data, int nbits);
        logic [SYN_W-1:0] w;
        w = '0;
        for (int k = 0; k < nbits; k++) begin
            if (data[lane_bit(k)]) w ^= SYN_W'(code_pos[k]);
        end
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] flip_data_bit(logic [DATA_W-1:0] data, int k);
        return data ^ (64'd1 << lane_bit(k));
    endfunction

    function automatic t_access_result predict_access(logic act, logic [SLOT_W-1:0] slot_in,
                                                      logic [BC_W-1:0] bc,
                                                      logic [DATA_W-1:0] data);
        t_access_result   r;
        int               nbits;
        int               slot;
        int               hit;
        logic [SYN_W-1:0] syn;
        nbits           = covered_bits(bc);
        slot            = slot_in % DEPTH;
        r.data          = data;
        r.syndrome      = '0;
        r.checked       = 1'b0;
        r.corrected     = 1'b0;
        r.uncorrectable = 1'b0;
        if (act == ACT_WRITE) begin
            chk_mem[slot]   = calc_check_word(data, nbits);
            size_mem[slot]  = bc;
            valid_mem[slot] = 1'b1;
        end else if (valid_mem[slot] && size_mem[slot] == bc) begin
            syn        = calc_check_word(data, nbits) ^ chk_mem[slot];
            r.checked  = 1'b1;
            r.syndrome = syn;
            if (syn != '0) begin
                hit = -1;
                for (int k = 0; k < nbits; k++) begin
                    if (code_pos[k] == syn) hit = k;
                end
                // check positions and positions past the data give no hit
                if (hit >= 0) begin
                    r.data[lane_bit(hit)] = ~r.data[lane_bit(hit)];
                    r.corrected = 1'b1;
                end else begin
                    r.uncorrectable = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic log_error(string msg);
        errors++;
        if (errors <= MAX_SHOWN) $display("error at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin : result_check
        t_access_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                log_error("result with no item outstanding");
            end else begin
                exp_r = expected_results.pop_front();
                if (o_data_out !== exp_r.data || o_syndrome !== exp_r.syndrome ||
                    o_checked !== exp_r.checked || o_corrected !== exp_r.corrected ||
                    o_uncorrectable !== exp_r.uncorrectable) begin
                    log_error($sformatf(
                        "exp data %h syn %h chk %b cor %b unc %b, got data %h syn %h chk %b cor %b unc %b",
                        exp_r.data, exp_r.syndrome, exp_r.checked, exp_r.corrected,
                        exp_r.uncorrectable, o_data_out, o_syndrome, o_checked,
                        o_corrected, o_uncorrectable));
                end
            end
        end
    end

    // present one item after a random gap and wait until it is taken
    task automatic send_item(logic act, logic [SLOT_W-1:0] slot, logic [BC_W-1:0] bc,
                             logic [DATA_W-1:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_slot       <= slot;
        i_byte_count <= bc;
        i_data_in    <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(predict_access(act, slot, bc, data));
        if (act == ACT_WRITE) begin
            if (!wr_seen[slot]) written_slots.push_back(slot);
            wr_seen[slot]  = 1'b1;
            wr_data[slot]  = data;
            wr_count[slot] = bc;
            last_written   = slot;
        end
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        logic [DATA_W-1:0] d;
        idle_pct  = 0;
        stall_pct = 0;
        // extremes of slot, count and data, read straight after write
        send_item(ACT_WRITE, 10'd0, 4'd1, 64'd0);
        send_item(ACT_READ, 10'd0, 4'd1, 64'd0);
        send_item(ACT_WRITE, 10'd1023, 4'd8, '1);
        send_item(ACT_READ, 10'd1023, 4'd8, '1);
        send_item(ACT_READ, 10'd1023, 4'd8, flip_data_bit('1, 0));
        send_item(ACT_READ, 10'd1023, 4'd8, flip_data_bit('1, 63));
        // size differs: passed through unchecked
        send_item(ACT_READ, 10'd1023, 4'd7, '1);
        // count of zero covers one byte, upper bytes pass untouched
        d = {$urandom, $urandom};
        send_item(ACT_WRITE, 10'd5, 4'd0, d);
        send_item(ACT_READ, 10'd5, 4'd0, d ^ 64'hffff_ffff_ffff_ff00);
        // two flips whose positions xor to a check position
        send_item(ACT_READ, 10'd5, 4'd0, flip_data_bit(flip_data_bit(d, 0), 3));
        // two flips whose positions xor past the last covered position
        send_item(ACT_READ, 10'd5, 4'd0, flip_data_bit(flip_data_bit(d, 0), 7));
        // counts above the maximum are clamped for coverage, compared raw
        d = {$urandom, $urandom};
        send_item(ACT_WRITE, 10'd9, 4'd15, d);
        send_item(ACT_READ, 10'd9, 4'd15, flip_data_bit(d, 10));
        send_item(ACT_READ, 10'd9, 4'd8, d);
        // overwrite a slot with a new size
        send_item(ACT_WRITE, 10'd0, 4'd8, d);
        send_item(ACT_READ, 10'd0, 4'd1, d);
        send_item(ACT_READ, 10'd0, 4'd8, flip_data_bit(d, 32));
        send_item(ACT_READ, 10'd0, 4'd8, flip_data_bit(flip_data_bit(d, 20), 45));
        pause_until_drained();
    endtask

    task automatic test_random_traffic(int count, int phase_idle, int phase_stall);
        int                r;
        int                slot;
        int                nbits;
        int                kind;
        logic [BC_W-1:0]   bc;
        logic [DATA_W-1:0] d;
        for (int n = 0; n < count; n++) begin
            // occasional calm stretches with no idling at all
            if (n % 40 == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end else begin
                    idle_pct  = phase_idle;
                    stall_pct = phase_stall;
                end
            end
            if (n == count / 2) pause_until_drained();
            r = $urandom_range(0, 99);
            if (written_slots.size() == 0 || r < 30) begin
                slot = $urandom_range(0, 1) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, 15);
                bc   = ($urandom_range(0, 9) == 0) ? BC_W'($urandom_range(0, 15))
                                                   : BC_W'($urandom_range(1, MAX_BYTES));
                send_item(ACT_WRITE, SLOT_W'(slot), bc, {$urandom, $urandom});
            end else begin
                slot = ($urandom_range(0, 9) < 4) ? last_written
                     : written_slots[$urandom_range(0, written_slots.size() - 1)];
                if (r < 88) begin
                    bc    = wr_count[slot];
                    d     = wr_data[slot];
                    nbits = covered_bits(bc);
                    kind  = $urandom_range(0, 9);
                    if (kind >= 3 && kind <= 6) begin
                        d = flip_data_bit(d, $urandom_range(0, nbits - 1));
                    end else if (kind == 7 || kind == 8) begin
                        d = flip_data_bit(d, $urandom_range(0, nbits - 1));
                        d = flip_data_bit(d, $urandom_range(0, nbits - 1));
                    end else if (kind == 9) begin
                        d[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
                    end
                    send_item(ACT_READ, SLOT_W'(slot), bc, d);
                end else begin
                    send_item(ACT_READ, SLOT_W'(slot), BC_W'($urandom_range(0, 15)),
                              {$urandom, $urandom});
                end
            end
        end
        pause_until_drained();
    endtask

    initial begin : main
        int p;
        p = 1;
        for (int k = 0; k < DATA_W; k++) begin
            while ((p & (p - 1)) == 0) p++;
            code_pos[k] = p;
            p++;
        end
        for (int s = 0; s < DEPTH; s++) begin
            valid_mem[s] = 1'b0;
            wr_seen[s]   = 1'b0;
        end
        last_written = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(335, 0, 0);
        test_random_traffic(335, 63, 0);
        test_random_traffic(335, 0, 63);
        test_random_traffic(335, 22, 22);
        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_ram.sv
hw/rtl/hsc_slot_map.sv
hw/rtl/hsc_codec.sv
hw/rtl/hamming_sec_check_store.sv
tb/sv/tb_top.sv
